[hw/rtl/ter_pkg.sv]
// shared types, opcodes and defaults for the timestamped event ring
package ter_pkg;

	localparam int RING_DEPTH_DEF   = 16;
	localparam int PAYLOAD_BITS_DEF = 64;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_TRIM   = 2'd1,
		OP_PEEK   = 2'd2,
		OP_LATEST = 2'd3
	} op_t;

	// read address source for the ring memory
	typedef enum logic [1:0] {
		RD_OLDEST = 2'd0,
		RD_WALK   = 2'd1,
		RD_PEEK   = 2'd2,
		RD_NEWEST = 2'd3
	} rd_sel_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] entry_timestamp;
		logic [63:0] entry_payload;
		logic [31:0] watermark;
		logic [7:0]  peek_index;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] out_timestamp;
		logic [63:0] out_payload;
		logic [4:0]  entry_count;
		logic [31:0] oldest_stamp;
		logic [31:0] newest_stamp;
	} rsp_t;

	typedef struct packed {
		logic    capture;
		logic    add_write;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    set_oldest;
		logic    trim_step;
		logic    trim_finish;
		logic    load_result;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic walk_done;
		logic stamp_le;
	} sts_t;

endpackage

[hw/rtl/ter_ctrl.sv]
// sequencer for the timestamped event ring
module ter_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ter_pkg::op_t  opcode,
	input  ter_pkg::sts_t sts,
	output ter_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import ter_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_WR,
		S_RD_OLD,
		S_SET_OLD,
		S_TRIM_RD,
		S_TRIM_EV,
		S_TRIM_END,
		S_READ,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					case (opcode)
						OP_ADD:  state_d = S_ADD_WR;
						OP_TRIM: state_d = S_TRIM_RD;
						default: state_d = S_READ;
					endcase
				end
			end
			S_ADD_WR: begin
				cmd.add_write = 1'b1;
				state_d = sts.full ? S_RD_OLD : S_RESP;
			end
			S_RD_OLD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_OLDEST;
				state_d = S_SET_OLD;
			end
			S_SET_OLD: begin
				cmd.set_oldest = 1'b1;
				state_d = S_RESP;
			end
			S_TRIM_RD: begin
				if (sts.walk_done) begin
					state_d = S_TRIM_END;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_WALK;
					state_d = S_TRIM_EV;
				end
			end
			S_TRIM_EV: begin
				if (sts.stamp_le) begin
					cmd.trim_step = 1'b1;
					state_d = S_TRIM_RD;
				end else begin
					state_d = S_TRIM_END;
				end
			end
			S_TRIM_END: begin
				cmd.trim_finish = 1'b1;
				state_d = S_RESP;
			end
			S_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = (opcode == OP_PEEK) ? RD_PEEK : RD_NEWEST;
				state_d = S_RESP;
			end
			S_RESP: begin
				cmd.load_result = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == S_RESP);
		end
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
`endif

endmodule

[hw/rtl/ter_dp.sv]
// ring memory, pointers and result register for the timestamped event ring
module ter_dp #(
	parameter int RING_DEPTH   = ter_pkg::RING_DEPTH_DEF,
	parameter int PAYLOAD_BITS = ter_pkg::PAYLOAD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ter_pkg::req_t req,
	input  ter_pkg::cmd_t cmd,
	output ter_pkg::sts_t sts,
	output ter_pkg::op_t  opcode,
	output ter_pkg::rsp_t rsp
);
	import ter_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);

	// ring storage
	logic [31:0]             stamp_mem [RING_DEPTH];
	logic [PAYLOAD_BITS-1:0] pl_mem    [RING_DEPTH];

	req_t                    req_q;
	logic [PW-1:0]           wp_q;
	logic [PW-1:0]           old_ptr_q;
	logic [CW-1:0]           count_q;
	logic [PW-1:0]           walk_q;
	logic [CW-1:0]           trim_n_q;
	logic [31:0]             oldest_q;
	logic [31:0]             newest_q;
	logic [31:0]             rd_stamp_q;
	logic [PAYLOAD_BITS-1:0] rd_pl_q;
	rsp_t                    rsp_q;

	logic          empty;
	logic          full;
	logic          peek_hit;
	logic [PW:0]   peek_sum;
	logic [PW-1:0] peek_slot;
	logic [PW-1:0] newest_slot;
	logic [PW-1:0] rd_addr;
	logic [PW:0]   ring_sum;
	logic [PW-1:0] ring_end;
	rsp_t          rsp_d;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(RING_DEPTH));
	assign peek_hit = (req_q.peek_index < 8'(count_q));

	// age offset from oldest, wrapped once
	assign peek_sum  = (PW+1)'(old_ptr_q) + (PW+1)'(req_q.peek_index[PW-1:0]);
	always_comb begin
		if (!peek_hit) begin
			peek_slot = old_ptr_q;
		end else if (peek_sum >= (PW+1)'(RING_DEPTH)) begin
			peek_slot = PW'(peek_sum - (PW+1)'(RING_DEPTH));
		end else begin
			peek_slot = PW'(peek_sum);
		end
	end

	assign newest_slot = (wp_q == '0) ? PW'(RING_DEPTH - 1) : wp_q - 1'b1;

	always_comb begin
		case (cmd.rd_sel)
			RD_OLDEST: rd_addr = old_ptr_q;
			RD_WALK:   rd_addr = walk_q;
			RD_PEEK:   rd_addr = peek_slot;
			RD_NEWEST: rd_addr = newest_slot;
			default:   rd_addr = old_ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			stamp_mem[wp_q] <= req_q.entry_timestamp;
			pl_mem[wp_q]    <= req_q.entry_payload[PAYLOAD_BITS-1:0];
		end
		if (cmd.rd_en) begin
			rd_stamp_q <= stamp_mem[rd_addr];
			rd_pl_q    <= pl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			old_ptr_q <= '0;
			count_q   <= '0;
			walk_q    <= '0;
			trim_n_q  <= '0;
		end else begin
			if (cmd.capture) begin
				walk_q   <= old_ptr_q;
				trim_n_q <= '0;
			end
			if (cmd.add_write) begin
				wp_q <= ptr_inc(wp_q);
				if (full) begin
					old_ptr_q <= ptr_inc(old_ptr_q);
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.trim_step) begin
				walk_q   <= ptr_inc(walk_q);
				trim_n_q <= trim_n_q + 1'b1;
			end
			if (cmd.trim_finish && (trim_n_q != '0)) begin
				if (trim_n_q >= count_q) begin
					count_q   <= '0;
					wp_q      <= '0;
					old_ptr_q <= '0;
				end else begin
					count_q   <= count_q - trim_n_q;
					old_ptr_q <= walk_q;
				end
			end
		end
	end

	// cached end stamps, only read while the ring holds entries
	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			newest_q <= req_q.entry_timestamp;
			if (empty) begin
				oldest_q <= req_q.entry_timestamp;
			end
		end
		if (cmd.set_oldest) begin
			oldest_q <= rd_stamp_q;
		end
		if (cmd.trim_finish && (trim_n_q != '0) && (trim_n_q < count_q)) begin
			oldest_q <= rd_stamp_q;
		end
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.entry_count = 5'(count_q);
		if (!empty) begin
			rsp_d.oldest_stamp = oldest_q;
			rsp_d.newest_stamp = newest_q;
		end
		case (req_q.opcode)
			OP_ADD, OP_TRIM: begin
				rsp_d.ok = 1'b1;
			end
			OP_PEEK: begin
				rsp_d.ok = peek_hit;
			end
			OP_LATEST: begin
				rsp_d.ok = !empty;
			end
			default: begin
				rsp_d.ok = 1'b0;
			end
		endcase
		if (rsp_d.ok && ((req_q.opcode == OP_PEEK) || (req_q.opcode == OP_LATEST))) begin
			rsp_d.out_timestamp = rd_stamp_q;
			rsp_d.out_payload   = 64'(rd_pl_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp    = rsp_q;
	assign opcode = req_q.opcode;

	assign sts.full      = full;
	assign sts.walk_done = (trim_n_q == count_q);
	assign sts.stamp_le  = (rd_stamp_q <= req_q.watermark);

	// write pointer sits count entries past the oldest one
	assign ring_sum = (PW+1)'(old_ptr_q) + (PW+1)'(count_q);
	assign ring_end = (ring_sum >= (PW+1)'(RING_DEPTH)) ?
		PW'(ring_sum - (PW+1)'(RING_DEPTH)) : PW'(ring_sum);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RING_DEPTH))
		else $error("entry count beyond ring depth");
	a_ring_span: assert property (@(posedge clk) disable iff (!arst_n)
		ring_end == wp_q)
		else $error("write pointer out of step with oldest pointer and count");
	a_empty_home: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wp_q == '0) && (old_ptr_q == '0))
		else $error("empty ring with pointers away from slot zero");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trim_step |=> trim_n_q <= count_q)
		else $error("trim walk ran past the entry count");
`endif

endmodule

[hw/rtl/timestamped_event_ring.sv]
// top level of the timestamped event ring: sequencer plus ring datapath
//
//  channel   direction  handshake              payload
//  request   in         start high, busy low   req (ter_pkg::req_t)
//  result    out        done, one cycle        rsp (ter_pkg::rsp_t)
//
// add writes the entry, then loads the result; on a full ring it also
//   reads the ring memory once more to fetch the new oldest stamp
// peek and latest make one registered read of the ring memory
// trim walks the ring from the oldest entry, reading each one and then
//   comparing it with the watermark; it stops at the first newer entry,
//   or when it has removed every entry in the ring
// reset clears the pointers and the count; the ring memory needs no clearing
// the result sits on rsp while done is high, for exactly one cycle; the
//   receiver cannot stall it, and busy is already low in that cycle
module timestamped_event_ring #(
	parameter int RING_DEPTH   = ter_pkg::RING_DEPTH_DEF,
	parameter int PAYLOAD_BITS = ter_pkg::PAYLOAD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ter_pkg::req_t req,
	output logic          done,
	output ter_pkg::rsp_t rsp
);
	import ter_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;
	op_t  held_op;
	op_t  ctrl_op;

	// at the accept edge the opcode comes straight from the port, after that
	// from the captured request
	assign ctrl_op = busy ? held_op : req.opcode;

	ter_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (ctrl_op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ter_dp #(
		.RING_DEPTH   (RING_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.opcode (held_op),
		.rsp    (rsp)
	);

endmodule
